[hw/rtl/mceg_pkg.sv]
`timescale 1ns / 1ps

package mceg_pkg;

    typedef enum logic [2:0] {
        EV_MOVE  = 3'd0,
        EV_STOP  = 3'd1,
        EV_LDOWN = 3'd2,
        EV_LUP   = 3'd3,
        EV_LDRAG = 3'd4,
        EV_RDOWN = 3'd5,
        EV_RUP   = 3'd6,
        EV_RDRAG = 3'd7
    } event_kind_t;

    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [2:0] REG_RECT_LEFT   = 3'd0;
    localparam logic [2:0] REG_RECT_TOP    = 3'd1;
    localparam logic [2:0] REG_RECT_RIGHT  = 3'd2;
    localparam logic [2:0] REG_RECT_BOTTOM = 3'd3;
    localparam logic [2:0] REG_IDLE_LIMIT  = 3'd4;
    localparam logic [2:0] REG_KEY_FLAGS   = 3'd5;

    localparam logic signed [15:0] RECT_LEFT_RST   = 16'sd0;
    localparam logic signed [15:0] RECT_TOP_RST    = 16'sd0;
    localparam logic signed [15:0] RECT_RIGHT_RST  = 16'sd800;
    localparam logic signed [15:0] RECT_BOTTOM_RST = 16'sd600;
    localparam logic [15:0]        IDLE_LIMIT_RST  = 16'd500;
    localparam logic [7:0]         KEY_FLAGS_RST   = 8'd0;

    localparam int           MAX_EVENTS = 3;
    localparam logic [15:0]  IDLE_SAT   = 16'hFFFF;

endpackage

[hw/rtl/mouse_cursor_event_generator_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  command, delta_x, delta_y, left_raw, right_raw
// output    out        out_valid/out_stall event_kind, event_x, event_y, event_keys, last_event
// config    in         cfg_we             cfg_index, cfg_wdata
//
// A report is decoded in the cycle it is accepted and its events (zero to three)
// land in a pending buffer; the output register takes one event per cycle from it
// while the output is not stalled. A new report can be accepted while the last
// pending event of the previous one moves into the single output register. The first
// event passes through the pending buffer and then the output register. Reset clears
// cursor, button history, idle timer, pending event count and output valid, and sets
// the configuration registers to their reset values. in_stall is high while two or
// three events are pending, or one is pending and the output register is stalled.

module mouse_cursor_event_generator_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      command,
    input  logic signed [15:0]        delta_x,
    input  logic signed [15:0]        delta_y,
    input  logic [7:0]                left_raw,
    input  logic [7:0]                right_raw,

    output logic                      out_valid,
    input  logic                      out_stall,
    output mceg_pkg::event_kind_t     event_kind,
    output logic signed [15:0]        event_x,
    output logic signed [15:0]        event_y,
    output logic [7:0]                event_keys,
    output logic                      last_event,

    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [15:0]               cfg_wdata
);

    import mceg_pkg::*;

    localparam int SUM_W = ((COORD_BITS > 17) ? COORD_BITS : 17) + 1;
    localparam logic signed [SUM_W-1:0] CMAX =
        SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] CMIN = ~CMAX;

    // configuration
    logic signed [15:0] rect_left_reg, rect_top_reg, rect_right_reg, rect_bottom_reg;
    logic [15:0]        idle_limit_reg;
    logic [7:0]         key_flags_reg;

    // block state
    logic signed [COORD_BITS-1:0] cursor_x_reg, cursor_y_reg;
    logic [7:0]                   left_prev_reg, right_prev_reg;
    logic                         idle_running_reg;
    logic [15:0]                  idle_count_reg;

    // pending events of the last report
    event_kind_t        pend_kind_reg [MAX_EVENTS];
    logic [1:0]         pend_cnt_reg;
    logic signed [15:0] pend_x_reg, pend_y_reg;
    logic [7:0]         pend_keys_reg;

    // output register
    logic               out_valid_reg;
    event_kind_t        out_kind_reg;
    logic signed [15:0] out_x_reg, out_y_reg;
    logic [7:0]         out_keys_reg;
    logic               out_last_reg;

    logic in_accept, out_move, pop, is_report, motion;

    logic signed [COORD_BITS-1:0] cursor_x_next, cursor_y_next;
    logic signed [SUM_W-1:0]      cx_ext, cy_ext;
    event_kind_t                  ev_kind [MAX_EVENTS];
    logic [1:0]                   ev_cnt;

    function automatic logic signed [SUM_W-1:0] step_coord(
        input logic signed [COORD_BITS-1:0] cur,
        input logic signed [15:0]           delta,
        input logic signed [15:0]           lo,
        input logic signed [15:0]           hi
    );
        logic signed [SUM_W-1:0] cur_e, d_e, lo_e, hi_e, v;
        begin
            cur_e = {{(SUM_W-COORD_BITS){cur[COORD_BITS-1]}}, cur};
            d_e   = {{(SUM_W-16){delta[15]}}, delta};
            lo_e  = {{(SUM_W-16){lo[15]}}, lo};
            hi_e  = {{(SUM_W-16){hi[15]}}, hi};
            v = cur_e + (d_e <<< 1);
            if (v < lo_e) v = lo_e;
            if (v > hi_e) v = hi_e;
            if (v < CMIN) v = CMIN;
            if (v > CMAX) v = CMAX;
            return v;
        end
    endfunction

    assign out_move  = !out_valid_reg || !out_stall;
    assign pop       = (pend_cnt_reg != 2'd0) && out_move;
    assign in_stall  = !((pend_cnt_reg == 2'd0) || ((pend_cnt_reg == 2'd1) && out_move));
    assign in_accept = in_valid && !in_stall;
    assign is_report = (command == CMD_REPORT);
    assign motion    = (delta_x != 16'sd0) || (delta_y != 16'sd0);

    always_comb
    begin
        cx_ext = step_coord(cursor_x_reg, delta_x, rect_left_reg, rect_right_reg);
        cy_ext = step_coord(cursor_y_reg, delta_y, rect_top_reg, rect_bottom_reg);
        cursor_x_next = cx_ext[COORD_BITS-1:0];
        cursor_y_next = cy_ext[COORD_BITS-1:0];
    end

    // Build the event list in report order: motion or stop, left, right.
    always_comb
    begin
        for (int i = 0; i < MAX_EVENTS; i++)
        begin
            ev_kind[i] = EV_MOVE;
        end
        ev_cnt = 2'd0;
        if (motion)
        begin
            ev_kind[0] = EV_MOVE;
            ev_cnt     = 2'd1;
        end
        else if (idle_running_reg && (idle_count_reg >= idle_limit_reg))
        begin
            ev_kind[0] = EV_STOP;
            ev_cnt     = 2'd1;
        end
        if (left_raw != left_prev_reg)
        begin
            ev_kind[ev_cnt] = left_raw[7] ? EV_LDOWN : EV_LUP;
            ev_cnt          = ev_cnt + 2'd1;
        end
        else if (left_prev_reg[7])
        begin
            ev_kind[ev_cnt] = EV_LDRAG;
            ev_cnt          = ev_cnt + 2'd1;
        end
        if (right_raw != right_prev_reg)
        begin
            ev_kind[ev_cnt] = right_raw[7] ? EV_RDOWN : EV_RUP;
            ev_cnt          = ev_cnt + 2'd1;
        end
        else if (right_prev_reg[7])
        begin
            ev_kind[ev_cnt] = EV_RDRAG;
            ev_cnt          = ev_cnt + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg   <= RECT_LEFT_RST;
            rect_top_reg    <= RECT_TOP_RST;
            rect_right_reg  <= RECT_RIGHT_RST;
            rect_bottom_reg <= RECT_BOTTOM_RST;
            idle_limit_reg  <= IDLE_LIMIT_RST;
            key_flags_reg   <= KEY_FLAGS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RECT_LEFT:   rect_left_reg   <= cfg_wdata;
                REG_RECT_TOP:    rect_top_reg    <= cfg_wdata;
                REG_RECT_RIGHT:  rect_right_reg  <= cfg_wdata;
                REG_RECT_BOTTOM: rect_bottom_reg <= cfg_wdata;
                REG_IDLE_LIMIT:  idle_limit_reg  <= cfg_wdata;
                REG_KEY_FLAGS:   key_flags_reg   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            left_prev_reg    <= '0;
            right_prev_reg   <= '0;
            idle_running_reg <= 1'b0;
            idle_count_reg   <= '0;
        end
        else if (in_accept)
        begin
            if (!is_report)
            begin
                if (idle_running_reg && (idle_count_reg != IDLE_SAT))
                begin
                    idle_count_reg <= idle_count_reg + 16'd1;
                end
            end
            else
            begin
                cursor_x_reg   <= cursor_x_next;
                cursor_y_reg   <= cursor_y_next;
                left_prev_reg  <= left_raw;
                right_prev_reg <= right_raw;
                if (motion)
                begin
                    idle_running_reg <= 1'b0;
                end
                else if (!idle_running_reg)
                begin
                    idle_running_reg <= 1'b1;
                    idle_count_reg   <= '0;
                end
                else if (idle_count_reg >= idle_limit_reg)
                begin
                    idle_running_reg <= 1'b0;
                end
            end
        end
    end

    // Pending buffer: load a new report's events, else shift one out per pop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= 2'd0;
        end
        else if (in_accept && is_report && (ev_cnt != 2'd0))
        begin
            pend_cnt_reg <= ev_cnt;
        end
        else if (pop)
        begin
            pend_cnt_reg <= pend_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && is_report && (ev_cnt != 2'd0))
        begin
            for (int i = 0; i < MAX_EVENTS; i++)
            begin
                pend_kind_reg[i] <= ev_kind[i];
            end
            pend_x_reg    <= cx_ext[15:0];
            pend_y_reg    <= cy_ext[15:0];
            pend_keys_reg <= key_flags_reg;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_EVENTS - 1; i++)
            begin
                pend_kind_reg[i] <= pend_kind_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_move)
        begin
            out_valid_reg <= (pend_cnt_reg != 2'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_kind_reg <= pend_kind_reg[0];
            out_x_reg    <= pend_x_reg;
            out_y_reg    <= pend_y_reg;
            out_keys_reg <= pend_keys_reg;
            out_last_reg <= (pend_cnt_reg == 2'd1);
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign event_x    = out_x_reg;
    assign event_y    = out_y_reg;
    assign event_keys = out_keys_reg;
    assign last_event = out_last_reg;

    // A transaction that is not the last of its report is followed at once by the next.
    a_burst_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !out_last_reg) |=> out_valid_reg)
        else $error("event burst broken before last event");

    // Hold a stalled output transaction unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_kind_reg) &&
            $stable(out_x_reg) && $stable(out_y_reg) && $stable(out_keys_reg) &&
            $stable(out_last_reg)))
        else $error("stalled output transaction changed");

    // Motion in a report stops the idle timer.
    a_motion_stops_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && is_report && motion) |=> !idle_running_reg)
        else $error("idle timer still running after motion");

    // Input is never taken while two or more events wait.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_cnt_reg >= 2'd2) |-> in_stall)
        else $error("input accepted over pending events");

endmodule
